FILE: design/lrdcrc_pkg.sv
`default_nettype none

package lrdcrc_pkg;

  localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
  localparam logic [4:0]  HDR_LAST     = 5'd16;
  localparam logic [1:0]  CRC_LAST     = 2'd3;

  localparam int unsigned TDATA_W      = 144;

  typedef enum logic [3:0] {
    PH_CRC = 4'b0001,
    PH_HDR = 4'b0010,
    PH_KEY = 4'b0100,
    PH_VAL = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    KIND_REC_END = 2'd0,
    KIND_KEY     = 2'd1,
    KIND_VAL     = 2'd2,
    KIND_EOL     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_TRUNC    = 3'd3,
    ST_CLEAN    = 3'd4
  } status_e;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int j = 0; j < 8; j++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: design/log_record_deframer_crc32c.sv
// channel   dir  handshake                    tdata / tuser / tlast
// s_axis    in   s_axis_tvalid/s_axis_tready  log_byte / end_of_log / -
// m_axis    out  m_axis_tvalid/m_axis_tready  payload..sequence / item_kind / record_end
//
// One transfer per cycle: the CRC32C byte update and the record parser sit between the
// input handshake and the output register; a result shows the cycle after its byte.
// s_axis_tready drops while a result waits for m_axis_tready; nothing else stalls.
// Reset clears parser, header fields and halt flag; a checksum mismatch halts
// the block (inputs are taken and dropped) until the next reset.
`default_nettype none

module log_record_deframer_crc32c (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] log_byte
  input  wire logic         s_axis_tuser,   // [0] end_of_log
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [7:0] payload_byte, [10:8] record_status, [11] is_put, [43:12] key_length,
  // [75:44] value_length, [139:76] sequence_number, [143:140] zero
  output logic [lrdcrc_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]        m_axis_tuser,   // [1:0] item_kind
  output logic              m_axis_tlast    // record_end
);

  lrdcrc_pkg::phase_e phase_q, phase_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] stored_q, stored_d;
  logic [31:0] crc_q, crc_d;
  logic [7:0]  type_q, type_d;
  logic [31:0] klen_q, klen_d;
  logic [31:0] vlen_q, vlen_d;
  logic [63:0] seq_q, seq_d;
  logic [31:0] rem_q, rem_d;
  logic        halted_q, halted_d;

  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic [2:0]  out_status_q;
  logic        out_put_q;
  logic [31:0] out_klen_q;
  logic [31:0] out_vlen_q;
  logic [63:0] out_seq_q;

  logic        in_fire;
  logic        emit;
  logic        use_old;
  logic [1:0]  e_kind;
  logic [7:0]  e_byte;
  logic        e_last;
  logic [2:0]  e_status;
  logic [31:0] crc_upd;
  logic [4:0]  h_k;
  logic [4:0]  h_v;
  logic [4:0]  h_s;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign crc_upd       = lrdcrc_pkg::crc_byte(crc_q, s_axis_tdata);
  assign h_k           = cnt_q - 5'd1;
  assign h_v           = cnt_q - 5'd5;
  assign h_s           = cnt_q - 5'd9;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    stored_d = stored_q;
    crc_d    = crc_q;
    type_d   = type_q;
    klen_d   = klen_q;
    vlen_d   = vlen_q;
    seq_d    = seq_q;
    rem_d    = rem_q;
    halted_d = halted_q;
    emit     = 1'b0;
    use_old  = 1'b0;
    e_kind   = lrdcrc_pkg::KIND_REC_END;
    e_byte   = 8'd0;
    e_last   = 1'b0;
    e_status = lrdcrc_pkg::ST_BUSY;

    if (in_fire && !halted_q) begin
      if (s_axis_tuser) begin
        emit     = 1'b1;
        use_old  = 1'b1;
        e_kind   = lrdcrc_pkg::KIND_EOL;
        e_last   = 1'b1;
        e_status = (phase_q == lrdcrc_pkg::PH_CRC && cnt_q == 5'd0) ?
                   lrdcrc_pkg::ST_CLEAN : lrdcrc_pkg::ST_TRUNC;
        phase_d  = lrdcrc_pkg::PH_CRC;
        cnt_d    = 5'd0;
        stored_d = 32'd0;
        crc_d    = lrdcrc_pkg::CRC_INIT;
        type_d   = 8'd0;
        klen_d   = 32'd0;
        vlen_d   = 32'd0;
        seq_d    = 64'd0;
        rem_d    = 32'd0;
      end else begin
        unique case (phase_q)
          lrdcrc_pkg::PH_CRC: begin
            if (cnt_q == 5'd0) begin
              stored_d = 32'd0;
              type_d   = 8'd0;
              klen_d   = 32'd0;
              vlen_d   = 32'd0;
              seq_d    = 64'd0;
              crc_d    = lrdcrc_pkg::CRC_INIT;
            end
            stored_d[{cnt_q[1:0], 3'b000} +: 8] = s_axis_tdata;
            if (cnt_q[1:0] == lrdcrc_pkg::CRC_LAST) begin
              phase_d = lrdcrc_pkg::PH_HDR;
              cnt_d   = 5'd0;
            end else begin
              cnt_d = cnt_q + 5'd1;
            end
          end
          lrdcrc_pkg::PH_HDR: begin
            crc_d = crc_upd;
            if (cnt_q == 5'd0) begin
              type_d = s_axis_tdata;
            end else if (cnt_q <= 5'd4) begin
              klen_d[{h_k[1:0], 3'b000} +: 8] = s_axis_tdata;
            end else if (cnt_q <= 5'd8) begin
              vlen_d[{h_v[1:0], 3'b000} +: 8] = s_axis_tdata;
            end else begin
              seq_d[{h_s[2:0], 3'b000} +: 8] = s_axis_tdata;
            end
            if (cnt_q == lrdcrc_pkg::HDR_LAST) begin
              cnt_d = 5'd0;
              if (klen_d != 32'd0) begin
                phase_d = lrdcrc_pkg::PH_KEY;
                rem_d   = klen_d;
              end else if (vlen_d != 32'd0) begin
                phase_d = lrdcrc_pkg::PH_VAL;
                rem_d   = vlen_d;
              end else begin
                emit    = 1'b1;
                e_kind  = lrdcrc_pkg::KIND_REC_END;
                e_last  = 1'b1;
                phase_d = lrdcrc_pkg::PH_CRC;
                crc_d   = lrdcrc_pkg::CRC_INIT;
                rem_d   = 32'd0;
                if ((crc_upd ^ lrdcrc_pkg::CRC_INIT) == stored_q) begin
                  e_status = lrdcrc_pkg::ST_GOOD;
                end else begin
                  e_status = lrdcrc_pkg::ST_MISMATCH;
                  halted_d = 1'b1;
                end
              end
            end else begin
              cnt_d = cnt_q + 5'd1;
            end
          end
          lrdcrc_pkg::PH_KEY, lrdcrc_pkg::PH_VAL: begin
            crc_d  = crc_upd;
            rem_d  = rem_q - 32'd1;
            emit   = 1'b1;
            e_kind = (phase_q == lrdcrc_pkg::PH_KEY) ?
                     lrdcrc_pkg::KIND_KEY : lrdcrc_pkg::KIND_VAL;
            e_byte = s_axis_tdata;
            if (rem_q == 32'd1) begin
              if (phase_q == lrdcrc_pkg::PH_KEY && vlen_q != 32'd0) begin
                phase_d = lrdcrc_pkg::PH_VAL;
                rem_d   = vlen_q;
              end else begin
                e_last  = 1'b1;
                phase_d = lrdcrc_pkg::PH_CRC;
                cnt_d   = 5'd0;
                crc_d   = lrdcrc_pkg::CRC_INIT;
                rem_d   = 32'd0;
                if ((crc_upd ^ lrdcrc_pkg::CRC_INIT) == stored_q) begin
                  e_status = lrdcrc_pkg::ST_GOOD;
                end else begin
                  e_status = lrdcrc_pkg::ST_MISMATCH;
                  halted_d = 1'b1;
                end
              end
            end
          end
          default: begin
            phase_d  = lrdcrc_pkg::PH_CRC;
            cnt_d    = 5'd0;
            stored_d = 32'd0;
            crc_d    = lrdcrc_pkg::CRC_INIT;
            type_d   = 8'd0;
            klen_d   = 32'd0;
            vlen_d   = 32'd0;
            seq_d    = 64'd0;
            rem_d    = 32'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lrdcrc_pkg::PH_CRC;
      cnt_q       <= 5'd0;
      stored_q    <= 32'd0;
      crc_q       <= lrdcrc_pkg::CRC_INIT;
      type_q      <= 8'd0;
      klen_q      <= 32'd0;
      vlen_q      <= 32'd0;
      seq_q       <= 64'd0;
      rem_q       <= 32'd0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      stored_q <= stored_d;
      crc_q    <= crc_d;
      type_q   <= type_d;
      klen_q   <= klen_d;
      vlen_q   <= vlen_d;
      seq_q    <= seq_d;
      rem_q    <= rem_d;
      halted_q <= halted_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_kind_q   <= e_kind;
      out_byte_q   <= e_byte;
      out_last_q   <= e_last;
      out_status_q <= e_status;
      out_put_q    <= use_old ? (type_q == 8'd1) : (type_d == 8'd1);
      out_klen_q   <= use_old ? klen_q : klen_d;
      out_vlen_q   <= use_old ? vlen_q : vlen_d;
      out_seq_q    <= use_old ? seq_q : seq_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {4'd0, out_seq_q, out_vlen_q, out_klen_q, out_put_q,
                          out_status_q, out_byte_q};

endmodule

`default_nettype wire

FILE: design/lrdcrc_sva.sv
`default_nettype none

module lrdcrc_sva (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [lrdcrc_pkg::TDATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]   m_axis_tuser,
  input wire logic         m_axis_tlast
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[10:8] != lrdcrc_pkg::ST_BUSY)))
    else $error("record_end and status disagree");

  a_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == lrdcrc_pkg::KIND_EOL |->
      m_axis_tlast && (m_axis_tdata[10:8] == lrdcrc_pkg::ST_TRUNC ||
                       m_axis_tdata[10:8] == lrdcrc_pkg::ST_CLEAN))
    else $error("end of log with bad status");

  a_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == lrdcrc_pkg::KIND_EOL ||
                      m_axis_tuser == lrdcrc_pkg::KIND_REC_END) |->
      m_axis_tdata[7:0] == 8'd0)
    else $error("payload byte on a non-payload item");

  a_halt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata[10:8] == lrdcrc_pkg::ST_MISMATCH |=>
      !m_axis_tvalid)
    else $error("output after checksum mismatch");

endmodule

bind log_record_deframer_crc32c lrdcrc_sva u_lrdcrc_sva (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
